// ===== rtl/bfsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Shortest path engine package
// Sizes, register indexes and stored entry formats shared by the engine files.
// ----------------------------------------------------------------------------
package bfsp_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VERTEX_W     = $clog2(MAX_VERTICES);
    localparam int COUNT_W      = VERTEX_W + 1;
    localparam int STORE_DEPTH  = MAX_VERTICES * MAX_VERTICES;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int WEIGHT_W     = 16;
    localparam int DIST_W       = 24;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_VERTEX = 1'b1;

    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = COUNT_W'(MAX_VERTICES);

    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    typedef struct packed {
        logic                       present;
        logic signed [WEIGHT_W-1:0] weight;
    } weight_entry_t;

    typedef struct packed {
        logic                     reachable;
        logic signed [DIST_W-1:0] dist_value;
    } dist_entry_t;

endpackage

// ===== rtl/bfsp_if.sv =====
// ----------------------------------------------------------------------------
// Shortest path engine channels
// Valid/ready channels for matrix entries in and vertex distances out.
// ----------------------------------------------------------------------------
interface bfsp_in_if;
    import bfsp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [WEIGHT_W-1:0] edge_weight;
    logic                       edge_present;
    logic                       last_entry;

    modport source (output valid, output edge_weight, output edge_present,
                    output last_entry, input ready);
    modport sink (input valid, input edge_weight, input edge_present,
                  input last_entry, output ready);
endinterface

interface bfsp_out_if;
    import bfsp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [VERTEX_W-1:0]      vertex_index;
    logic signed [DIST_W-1:0] distance;
    logic                     reachable;
    logic                     last_result;

    modport source (output valid, output vertex_index, output distance,
                    output reachable, output last_result, input ready);
    modport sink (input valid, input vertex_index, input distance,
                  input reachable, input last_result, output ready);
endinterface

// ===== rtl/bellman_ford_matrix_shortest_paths_top.sv =====
// ----------------------------------------------------------------------------
// Bellman-Ford shortest path engine
// Loads a dense weight matrix one entry per transaction, then relaxes every
// vertex pair with one shared add, saturate and compare unit and returns one
// distance per vertex.
// Entries are accepted back to back while loading. After the last entry,
// with n vertices, the distances are set up, then (n-1) passes relax each
// vertex pair in turn via the single read ports of the weight and distance
// memories. Results go out in vertex order; no entry is taken meanwhile.
// Reset sets vertex_count to 16, start_vertex to 0 and the load position to
// 0; the weight and distance memories are not cleared.
// ----------------------------------------------------------------------------
module bellman_ford_matrix_shortest_paths_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [bfsp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bfsp_pkg::CFG_DATA_W-1:0]  cfg_data,
    bfsp_in_if.sink                         in_item,
    bfsp_out_if.source                      out_result
);
    import bfsp_pkg::*;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_ROW,
        ST_DUCAP,
        ST_READ,
        ST_RELAX,
        ST_OUT_RD,
        ST_OUT_LOAD,
        ST_OUT_WAIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [COUNT_W-1:0]     vertex_count_reg;
    logic [VERTEX_W-1:0]    start_vertex_reg;
    logic [ADDR_W-1:0]      load_pos_reg, load_pos_next;
    logic [COUNT_W-1:0]     n_reg, n_next;
    logic [VERTEX_W-1:0]    u_reg, u_next;
    logic [VERTEX_W-1:0]    v_reg, v_next;
    logic [VERTEX_W-1:0]    pass_reg, pass_next;
    logic [ADDR_W-1:0]      row_base_reg, row_base_next;
    dist_entry_t            du_reg, du_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VERTEX_W-1:0]    out_vertex_reg, out_vertex_next;
    logic signed [DIST_W-1:0] out_dist_reg, out_dist_next;
    logic                   out_reach_reg, out_reach_next;
    logic                   out_last_reg, out_last_next;

    weight_entry_t          weight_mem [STORE_DEPTH];
    weight_entry_t          w_rd_reg;
    dist_entry_t            dist_mem [MAX_VERTICES];
    dist_entry_t            dist_rd_reg;

    logic                   in_accept;
    logic                   out_accept;
    logic [COUNT_W-1:0]     eff_count;
    logic [VERTEX_W-1:0]    v_last;
    logic [ADDR_W-1:0]      w_raddr;
    logic [VERTEX_W-1:0]    dist_raddr;
    logic                   dist_we;
    dist_entry_t            dist_wdata;
    weight_entry_t          load_entry;
    logic signed [DIST_W:0] sum_wide;
    logic signed [DIST_W-1:0] sum_sat;
    logic                   relax_update;

    assign in_accept  = in_item.valid && in_item.ready;
    assign out_accept = out_result.valid && out_result.ready;
    assign v_last     = VERTEX_W'(n_reg - COUNT_W'(1));

    assign in_item.ready           = (state_reg == ST_LOAD);
    assign out_result.valid        = out_valid_reg;
    assign out_result.vertex_index = out_vertex_reg;
    assign out_result.distance     = out_dist_reg;
    assign out_result.reachable    = out_reach_reg;
    assign out_result.last_result  = out_last_reg;

    assign load_entry.present = in_item.edge_present;
    assign load_entry.weight  = in_item.edge_weight;

    always_comb
    begin
        if (vertex_count_reg == '0)
        begin
            eff_count = COUNT_W'(1);
        end
        else if (vertex_count_reg > COUNT_W'(MAX_VERTICES))
        begin
            eff_count = COUNT_W'(MAX_VERTICES);
        end
        else
        begin
            eff_count = vertex_count_reg;
        end
    end

    // Shared relaxation unit: saturating add followed by the signed compare.
    always_comb
    begin
        sum_wide = {du_reg.dist_value[DIST_W-1], du_reg.dist_value}
                 + {{(DIST_W+1-WEIGHT_W){w_rd_reg.weight[WEIGHT_W-1]}}, w_rd_reg.weight};
        if (sum_wide[DIST_W] != sum_wide[DIST_W-1])
        begin
            sum_sat = sum_wide[DIST_W] ? DIST_MIN : DIST_MAX;
        end
        else
        begin
            sum_sat = sum_wide[DIST_W-1:0];
        end
        relax_update = w_rd_reg.present && du_reg.reachable
                    && (!dist_rd_reg.reachable || (sum_sat < dist_rd_reg.dist_value));
    end

    assign w_raddr    = ADDR_W'(row_base_reg + ADDR_W'(v_reg));
    assign dist_raddr = (state_reg == ST_ROW) ? u_reg : v_reg;

    always_comb
    begin
        state_next      = state_reg;
        load_pos_next   = load_pos_reg;
        n_next          = n_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        pass_next       = pass_reg;
        row_base_next   = row_base_reg;
        du_next         = du_reg;
        out_valid_next  = out_valid_reg;
        out_vertex_next = out_vertex_reg;
        out_dist_next   = out_dist_reg;
        out_reach_next  = out_reach_reg;
        out_last_next   = out_last_reg;
        dist_we         = 1'b0;
        dist_wdata      = '0;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_accept)
                begin
                    load_pos_next = ADDR_W'(load_pos_reg + ADDR_W'(1));
                    if (in_item.last_entry)
                    begin
                        load_pos_next = '0;
                        n_next        = eff_count;
                        v_next        = '0;
                        state_next    = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                dist_we = 1'b1;
                if (v_reg == start_vertex_reg)
                begin
                    dist_wdata.reachable = 1'b1;
                end
                if (v_reg == v_last)
                begin
                    v_next        = '0;
                    u_next        = '0;
                    pass_next     = VERTEX_W'(1);
                    row_base_next = '0;
                    state_next    = (n_reg == COUNT_W'(1)) ? ST_OUT_RD : ST_ROW;
                end
                else
                begin
                    v_next = v_reg + VERTEX_W'(1);
                end
            end
            ST_ROW:
            begin
                state_next = ST_DUCAP;
            end
            ST_DUCAP:
            begin
                du_next    = dist_rd_reg;
                state_next = ST_RELAX;
            end
            ST_READ:
            begin
                state_next = ST_RELAX;
            end
            ST_RELAX:
            begin
                if (relax_update)
                begin
                    dist_we              = 1'b1;
                    dist_wdata.reachable = 1'b1;
                    dist_wdata.dist_value = sum_sat;
                    if (v_reg == u_reg)
                    begin
                        du_next.reachable  = 1'b1;
                        du_next.dist_value = sum_sat;
                    end
                end
                if (v_reg == v_last)
                begin
                    v_next = '0;
                    if (u_reg == v_last)
                    begin
                        u_next        = '0;
                        row_base_next = '0;
                        if (pass_reg == v_last)
                        begin
                            state_next = ST_OUT_RD;
                        end
                        else
                        begin
                            pass_next  = pass_reg + VERTEX_W'(1);
                            state_next = ST_ROW;
                        end
                    end
                    else
                    begin
                        u_next        = u_reg + VERTEX_W'(1);
                        row_base_next = ADDR_W'(row_base_reg + ADDR_W'(n_reg));
                        state_next    = ST_ROW;
                    end
                end
                else
                begin
                    v_next     = v_reg + VERTEX_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_LOAD;
            end
            ST_OUT_LOAD:
            begin
                out_valid_next  = 1'b1;
                out_vertex_next = v_reg;
                out_reach_next  = dist_rd_reg.reachable;
                out_dist_next   = dist_rd_reg.reachable ? dist_rd_reg.dist_value : '0;
                out_last_next   = (v_reg == v_last);
                state_next      = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (out_accept)
                begin
                    out_valid_next = 1'b0;
                    if (v_reg == v_last)
                    begin
                        v_next     = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        v_next     = v_reg + VERTEX_W'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            vertex_count_reg <= VERTEX_COUNT_RESET;
            start_vertex_reg <= '0;
            load_pos_reg     <= '0;
            n_reg            <= VERTEX_COUNT_RESET;
            u_reg            <= '0;
            v_reg            <= '0;
            pass_reg         <= '0;
            row_base_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_pos_reg  <= load_pos_next;
            n_reg         <= n_next;
            u_reg         <= u_next;
            v_reg         <= v_next;
            pass_reg      <= pass_next;
            row_base_reg  <= row_base_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_VERTEX_COUNT: vertex_count_reg <= COUNT_W'(cfg_data);
                    CFG_START_VERTEX: start_vertex_reg <= VERTEX_W'(cfg_data);
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        du_reg         <= du_next;
        out_vertex_reg <= out_vertex_next;
        out_dist_reg   <= out_dist_next;
        out_reach_reg  <= out_reach_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            weight_mem[load_pos_reg] <= load_entry;
        end
        w_rd_reg <= weight_mem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[v_reg] <= dist_wdata;
        end
        dist_rd_reg <= dist_mem[dist_raddr];
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_item.ready && out_result.valid))
        else $error("Entry port open while a result transaction is pending.");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_result.valid |-> (out_result.last_result == (out_result.vertex_index == v_last)))
        else $error("Last result flag does not match the final vertex.");

    a_unreached_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_result.valid && !out_result.reachable) |-> (out_result.distance == '0))
        else $error("Unreachable vertex reported with a non-zero distance.");

    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && out_result.last_result) |=> in_item.ready)
        else $error("Engine did not return to loading after the final result.");

    a_results_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && !out_result.last_result)
            |=> ##2 (out_result.valid
                     && out_result.vertex_index == $past(out_result.vertex_index, 3)
                        + VERTEX_W'(1)))
        else $error("Results are not delivered in vertex order.");

endmodule
